// ----- src/closest_cross_team_pair_defines.svh -----
// Assertion macros used by closest_cross_team_pair.
`ifndef CLOSEST_CROSS_TEAM_PAIR_DEFINES_SVH
`define CLOSEST_CROSS_TEAM_PAIR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("closest_cross_team_pair: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("closest_cross_team_pair: next-cycle check failed");

`endif

// ----- src/ccp_pkg.sv -----
package ccp_pkg;

    localparam int unsigned MAX_POINTS_DEF = 16;
    localparam int unsigned COORD_W        = 16;
    localparam int unsigned LIMIT_W        = 17;
    localparam int unsigned MAG_W          = COORD_W + 1;
    localparam int unsigned DIST_W         = 2 * MAG_W;
    localparam int unsigned IDX_OUT_W      = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd100000;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic                      side;
        logic                      active;
        logic                      last_point;
    } in_beat_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] source_index;
        logic [IDX_OUT_W-1:0] target_index;
    } out_beat_t;

    // One stored point: 50 bits.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      side;
        logic                      active;
    } point_t;

    localparam int unsigned POINT_W = $bits(point_t);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SRC_RD,
        ST_SRC_CHK,
        ST_TGT_RD,
        ST_TGT_CHK,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

endpackage

// ----- src/ccp_ram.sv -----
module ccp_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/closest_cross_team_pair.sv -----
// closest_cross_team_pair: while the block is loading, points arrive one beat
// per cycle on the input channel and are written into a MAX_POINTS-deep point
// RAM; beats that arrive while the RAM is full are dropped. The beat marked
// last_point starts a brute-force search over every (active side-0, active
// side-1) pair, side-0 points outer and side-1 points inner, both in load
// order. The pair with the smallest squared distance strictly below
// distance_limit squared wins, the first one found wins a tie, and one result
// beat carries the found flag and both load indices (masked to 4 bits, zero
// when nothing qualifies). The search is paced by the single point RAM read
// port (each point is fetched in a read state and checked in a check state)
// and by the one shared 17x17 multiplier, which squares the three axis
// differences of a pair one after another before the compare; a finished
// search may also wait for the output register to drain. The input channel
// is not ready during the search; a finished result sits in the output
// register, so the next point set can load while it waits to be taken.
// distance_limit may be written at any time through the config channel,
// which is always ready.

`include "closest_cross_team_pair_defines.svh"

module closest_cross_team_pair
    import ccp_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_beat_t           in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output out_beat_t          out_data
);

    localparam int unsigned IDX_W  = $clog2(MAX_POINTS);
    localparam int unsigned CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int unsigned WIDE_W = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    state_t state_reg, state_next;

    logic [LIMIT_W-1:0] limit_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   src_cnt_reg;
    logic [CNT_W-1:0]   tgt_cnt_reg;
    axis_t              axis_reg;
    point_t             src_pt_reg;
    point_t             tgt_pt_reg;
    logic [DIST_W-1:0]  acc_reg;
    logic [DIST_W-1:0]  best_reg;
    logic [IDX_W-1:0]   best_src_reg;
    logic [IDX_W-1:0]   best_tgt_reg;
    logic               best_found_reg;
    logic               out_valid_reg;
    out_beat_t          out_reg;

    // Point RAM ports.
    logic             ram_we;
    logic             ram_re;
    logic [IDX_W-1:0] ram_raddr;
    point_t           ram_rdata;
    point_t           ram_wdata;

    // Shared squaring unit.
    logic signed [COORD_W-1:0] coord_a;
    logic signed [COORD_W-1:0] coord_b;
    logic [MAG_W-1:0]          diff;
    logic [MAG_W-1:0]          mag;
    logic [MAG_W-1:0]          mul_op;
    logic [DIST_W-1:0]         prod;

    logic in_fire;
    logic out_free;
    logic src_end;
    logic tgt_end;
    logic src_hit;
    logic tgt_hit;
    logic [WIDE_W-1:0] src_wide;
    logic [WIDE_W-1:0] tgt_wide;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign src_end  = (src_cnt_reg == count_reg);
    assign tgt_end  = (tgt_cnt_reg == count_reg);
    assign src_hit  = ram_rdata.active && !ram_rdata.side;
    assign tgt_hit  = ram_rdata.active && ram_rdata.side;

    assign ram_wdata.x      = in_data.pos_x;
    assign ram_wdata.y      = in_data.pos_y;
    assign ram_wdata.z      = in_data.pos_z;
    assign ram_wdata.side   = in_data.side;
    assign ram_wdata.active = in_data.active;

    ccp_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_point_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Axis difference, magnitude and square.
    always_comb
    begin
        unique case (axis_reg)
            AXIS_X:
            begin
                coord_a = src_pt_reg.x;
                coord_b = tgt_pt_reg.x;
            end
            AXIS_Y:
            begin
                coord_a = src_pt_reg.y;
                coord_b = tgt_pt_reg.y;
            end
            AXIS_Z:
            begin
                coord_a = src_pt_reg.z;
                coord_b = tgt_pt_reg.z;
            end
            default:
            begin
                coord_a = src_pt_reg.z;
                coord_b = tgt_pt_reg.z;
            end
        endcase
    end

    assign diff   = {coord_a[COORD_W-1], coord_a} - {coord_b[COORD_W-1], coord_b};
    assign mag    = diff[MAG_W-1] ? (~diff + MAG_W'(1)) : diff;
    assign mul_op = (state_reg == ST_INIT) ? limit_reg : mag;
    assign prod   = DIST_W'(mul_op) * DIST_W'(mul_op);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && in_data.last_point)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = ST_SRC_RD;
            end
            ST_SRC_RD:
            begin
                state_next = src_end ? ST_DONE : ST_SRC_CHK;
            end
            ST_SRC_CHK:
            begin
                state_next = src_hit ? ST_TGT_RD : ST_SRC_RD;
            end
            ST_TGT_RD:
            begin
                state_next = tgt_end ? ST_SRC_RD : ST_TGT_CHK;
            end
            ST_TGT_CHK:
            begin
                state_next = tgt_hit ? ST_MUL : ST_TGT_RD;
            end
            ST_MUL:
            begin
                if (axis_reg == AXIS_Z)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_TGT_RD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = tgt_cnt_reg[IDX_W-1:0];
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                ram_we   = in_valid && (count_reg < CNT_MAX);
            end
            ST_SRC_RD:
            begin
                ram_re    = !src_end;
                ram_raddr = src_cnt_reg[IDX_W-1:0];
            end
            ST_TGT_RD:
            begin
                ram_re = !tgt_end;
            end
            ST_INIT, ST_SRC_CHK, ST_TGT_CHK, ST_MUL, ST_CMP, ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            // Advance the fill count, dropping beats once the RAM is full; clear it as the result is issued.
            if (ram_we)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (state_reg == ST_DONE && out_free)
            begin
                count_reg <= '0;
            end
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Search datapath.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_INIT:
            begin
                best_reg       <= prod;
                best_found_reg <= 1'b0;
                best_src_reg   <= '0;
                best_tgt_reg   <= '0;
                src_cnt_reg    <= '0;
            end
            ST_SRC_CHK:
            begin
                src_pt_reg  <= ram_rdata;
                tgt_cnt_reg <= '0;
                if (!src_hit)
                begin
                    src_cnt_reg <= src_cnt_reg + CNT_W'(1);
                end
            end
            ST_TGT_RD:
            begin
                if (tgt_end)
                begin
                    src_cnt_reg <= src_cnt_reg + CNT_W'(1);
                end
            end
            ST_TGT_CHK:
            begin
                tgt_pt_reg <= ram_rdata;
                acc_reg    <= '0;
                axis_reg   <= AXIS_X;
                if (!tgt_hit)
                begin
                    tgt_cnt_reg <= tgt_cnt_reg + CNT_W'(1);
                end
            end
            ST_MUL:
            begin
                acc_reg <= acc_reg + prod;
                unique case (axis_reg)
                    AXIS_X:  axis_reg <= AXIS_Y;
                    AXIS_Y:  axis_reg <= AXIS_Z;
                    default: axis_reg <= AXIS_X;
                endcase
            end
            ST_CMP:
            begin
                // Strict compare keeps the first pair on a tie.
                if (acc_reg < best_reg)
                begin
                    best_reg       <= acc_reg;
                    best_found_reg <= 1'b1;
                    best_src_reg   <= src_cnt_reg[IDX_W-1:0];
                    best_tgt_reg   <= tgt_cnt_reg[IDX_W-1:0];
                end
                tgt_cnt_reg <= tgt_cnt_reg + CNT_W'(1);
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_reg.found        <= best_found_reg;
                    out_reg.source_index <= src_wide[IDX_OUT_W-1:0];
                    out_reg.target_index <= tgt_wide[IDX_OUT_W-1:0];
                end
            end
            ST_LOAD, ST_SRC_RD:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Indices are zero unless a pair was found; mask to the 4-bit fields.
    assign src_wide = best_found_reg ? WIDE_W'(best_src_reg) : '0;
    assign tgt_wide = best_found_reg ? WIDE_W'(best_tgt_reg) : '0;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CCP_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX)
    `CCP_ASSERT_NOW(a_nofind_zero, clk, rst_n, out_valid && !out_data.found, out_data.source_index == '0 && out_data.target_index == '0)
    `CCP_ASSERT_NEXT(a_done_emits, clk, rst_n, state_reg == ST_DONE && out_free, out_valid && count_reg == '0 && state_reg == ST_LOAD)
    `CCP_ASSERT_NOW(a_ready_only_load, clk, rst_n, state_reg == ST_MUL || state_reg == ST_CMP, !in_ready && tgt_pt_reg.active && tgt_pt_reg.side && src_pt_reg.active && !src_pt_reg.side)

endmodule

// ----- tb/ccp_pair_checker.sv -----
module ccp_pair_checker
    import ccp_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [LIMIT_W-1:0] cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  in_beat_t           in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  out_beat_t          out_data,
    output int                 mismatches,
    output int                 pending
);

    point_t             held_points [MAX_POINTS];
    int unsigned        held_count = 0;
    logic [LIMIT_W-1:0] limit_now  = LIMIT_RESET;
    out_beat_t          expected_pairs [$];

    task automatic report_mismatch(input string what, input logic [IDX_OUT_W-1:0] got,
                                   input logic [IDX_OUT_W-1:0] want);
        $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
        mismatches = mismatches + 1;
    endtask

    // Squared difference on one axis, exact in 36 bits.
    function automatic bit [35:0] axis_sq(input logic signed [COORD_W-1:0] a,
                                          input logic signed [COORD_W-1:0] b);
        bit signed [35:0] wa;
        bit signed [35:0] wb;
        bit signed [35:0] d;
        wa = 36'(a);
        wb = 36'(b);
        d  = wa - wb;
        return d * d;
    endfunction

    // Closest active side-0 / side-1 pair of the held set, strictly inside the limit.
    function automatic out_beat_t closest_pair_of_set();
        bit [35:0] best;
        bit [35:0] d2;
        out_beat_t pick;
        best = limit_now * limit_now;
        pick = '0;
        for (int unsigned i = 0; i < held_count; i++)
        begin
            if (!held_points[i].active || held_points[i].side != 1'b0)
                continue;
            for (int unsigned j = 0; j < held_count; j++)
            begin
                if (!held_points[j].active || held_points[j].side != 1'b1)
                    continue;
                d2 = axis_sq(held_points[i].x, held_points[j].x)
                   + axis_sq(held_points[i].y, held_points[j].y)
                   + axis_sq(held_points[i].z, held_points[j].z);
                if (d2 < best)
                begin
                    best              = d2;
                    pick.found        = 1'b1;
                    pick.source_index = IDX_OUT_W'(i);
                    pick.target_index = IDX_OUT_W'(j);
                end
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            held_count = 0;
            limit_now  = LIMIT_RESET;
            expected_pairs.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_now = cfg_data;

            if (in_valid && in_ready)
            begin
                // drop points once the store is full
                if (held_count < MAX_POINTS)
                begin
                    held_points[held_count].x      = in_data.pos_x;
                    held_points[held_count].y      = in_data.pos_y;
                    held_points[held_count].z      = in_data.pos_z;
                    held_points[held_count].side   = in_data.side;
                    held_points[held_count].active = in_data.active;
                    held_count++;
                end
                if (in_data.last_point)
                begin
                    expected_pairs.insert(expected_pairs.size(), closest_pair_of_set());
                    held_count = 0;
                end
            end

            if (out_valid && out_ready)
            begin
                if (expected_pairs.size() == 0)
                    report_mismatch("result beat with nothing expected",
                                    out_data.source_index, '0);
                else
                begin
                    want = expected_pairs.pop_front();
                    if (out_data.found !== want.found)
                        report_mismatch("found", IDX_OUT_W'(out_data.found),
                                        IDX_OUT_W'(want.found));
                    if (out_data.source_index !== want.source_index)
                        report_mismatch("source_index", out_data.source_index,
                                        want.source_index);
                    if (out_data.target_index !== want.target_index)
                        report_mismatch("target_index", out_data.target_index,
                                        want.target_index);
                end
            end

            pending <= expected_pairs.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import ccp_pkg::*;

    localparam int unsigned POINT_SLOTS   = MAX_POINTS_DEF;
    localparam int unsigned RANDOM_POINTS = 1750;
    // Longest search: 16 held points split across both sides.
    localparam int unsigned SETTLE_CYCLES = 700;
    // Run limit in time units with a 20-unit clock period; the slowest correct run needs well under a third.
    localparam longint      RUN_LIMIT     = 64'd20_000_000;

    typedef enum int
    {
        SPREAD_WIDE,
        SPREAD_CLUSTER,
        SPREAD_EXTREME
    } spread_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [LIMIT_W-1:0] cfg_data;
    logic               in_valid;
    logic               in_ready;
    in_beat_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_beat_t          out_data;
    int                 mismatches;
    int                 pending;

    // When set, both sides run flat out with no gaps or stalls.
    bit                 quiet;
    int unsigned        points_sent;

    closest_cross_team_pair #(
        .MAX_POINTS (POINT_SLOTS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    ccp_pair_checker #(
        .MAX_POINTS (POINT_SLOTS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Gap length: mostly zero, sometimes short, rarely a long hold-off; always zero when quiet.
    function automatic int unsigned gap_len();
        int unsigned roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_beat_t make_point(input int x, input int y, input int z,
                                            input bit side, input bit active,
                                            input bit last);
        in_beat_t p;
        p.pos_x      = 16'(x);
        p.pos_y      = 16'(y);
        p.pos_z      = 16'(z);
        p.side       = side;
        p.active     = active;
        p.last_point = last;
        return p;
    endfunction

    // Offer one point beat after a random gap; hold valid and payload until taken.
    // Valid stays high afterwards so the next beat can follow back to back.
    task automatic push_point(input in_beat_t p);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (!in_ready);
        points_sent++;
    endtask

    // Drop valid and wait until every predicted result has been taken, then let
    // the block fall quiet. pending is registered, so wait for a clock edge before checking it.
    task automatic settle_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write the distance limit with the block idle.
    task automatic set_limit(input logic [LIMIT_W-1:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return LIMIT_W'(1);
            2:       return LIMIT_W'($urandom_range(2, 60));
            3:       return LIMIT_W'($urandom_range(60, 5000));
            4:       return LIMIT_RESET;
            5:       return '1;
            6:       return LIMIT_W'($urandom_range(60000, 120000));
            default: return LIMIT_W'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input spread_t style,
                                                      input logic [COORD_W-1:0] centre,
                                                      input int unsigned spread);
        case (style)
            SPREAD_CLUSTER:
                return centre + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
            SPREAD_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            default:
                return COORD_W'($urandom());
        endcase
    endfunction

    // One well-formed point set: random size, random geometry, last point at the end.
    // A few sets overrun the store so the tail beats get dropped.
    task automatic random_set();
        int unsigned           n;
        int unsigned           roll;
        int unsigned           spread;
        spread_t               style;
        logic [COORD_W-1:0]    cx;
        logic [COORD_W-1:0]    cy;
        logic [COORD_W-1:0]    cz;
        in_beat_t              p;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            n = $urandom_range(1, 8);
        else if (roll < 92)
            n = $urandom_range(9, POINT_SLOTS);
        else
            n = $urandom_range(POINT_SLOTS + 1, POINT_SLOTS + 4);

        roll = $urandom_range(0, 99);
        if (roll < 45)
            style = SPREAD_CLUSTER;
        else if (roll < 85)
            style = SPREAD_WIDE;
        else
            style = SPREAD_EXTREME;

        case ($urandom_range(0, 3))
            0:       spread = 1;
            1:       spread = 3;
            2:       spread = 40;
            default: spread = 2500;
        endcase
        cx = COORD_W'($urandom());
        cy = COORD_W'($urandom());
        cz = COORD_W'($urandom());

        for (int unsigned i = 0; i < n; i++)
        begin
            p.pos_x      = pick_coord(style, cx, spread);
            p.pos_y      = pick_coord(style, cy, spread);
            p.pos_z      = pick_coord(style, cz, spread);
            p.side       = 1'($urandom_range(0, 1));
            p.active     = ($urandom_range(0, 9) != 0);
            p.last_point = (i == n - 1);
            push_point(p);
        end
    endtask

    // Result side: take beats with random stalls (none when quiet), and ready stretches of random length between.
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat (gap_len() + 1) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned first_random;
        int unsigned sets_done;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        in_data     = '0;
        quiet       = 1'b0;
        points_sent = 0;
        sets_done   = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets, limit at its reset value first.
        // A lone point: no pair at all.
        push_point(make_point(0, 0, 0, 1'b0, 1'b1, 1'b1));
        // Opposite corners are about 113509 apart: outside the reset limit.
        push_point(make_point(-32768, -32768, -32768, 1'b0, 1'b1, 1'b0));
        push_point(make_point(32767, 32767, 32767, 1'b1, 1'b1, 1'b1));
        // Tie at distance 1: the earlier side-0 point wins; inactive points
        // sitting closer are skipped, and the target loads before the source.
        push_point(make_point(0, 0, 0, 1'b1, 1'b1, 1'b0));
        push_point(make_point(1, 0, 0, 1'b0, 1'b1, 1'b0));
        push_point(make_point(0, 0, 0, 1'b0, 1'b0, 1'b0));
        push_point(make_point(-1, 0, 0, 1'b1, 1'b1, 1'b0));
        push_point(make_point(0, 1, 0, 1'b0, 1'b1, 1'b0));
        push_point(make_point(1, 0, 0, 1'b1, 1'b0, 1'b1));

        // Limit zero: even coincident points do not qualify.
        set_limit('0);
        push_point(make_point(5, 5, 5, 1'b0, 1'b1, 1'b0));
        push_point(make_point(5, 5, 5, 1'b1, 1'b1, 1'b1));

        // Limit one: distance exactly one is rejected, distance zero kept.
        set_limit(LIMIT_W'(1));
        push_point(make_point(0, 0, 0, 1'b0, 1'b1, 1'b0));
        push_point(make_point(1, 0, 0, 1'b1, 1'b1, 1'b0));
        push_point(make_point(0, 0, 0, 1'b1, 1'b1, 1'b1));

        // Largest limit: opposite corners now qualify.
        set_limit('1);
        push_point(make_point(-32768, -32768, -32768, 1'b0, 1'b1, 1'b0));
        push_point(make_point(32767, 32767, 32767, 1'b1, 1'b1, 1'b1));

        // Random sets; new limit every few dozen sets, with the occasional
        // flat-out stretch and the occasional hold-off until all results are in.
        first_random = points_sent;
        while (points_sent < first_random + RANDOM_POINTS)
        begin
            if (sets_done % 40 == 0)
            begin
                quiet = ($urandom_range(0, 4) == 0);
                set_limit(pick_limit());
            end
            random_set();
            sets_done++;
            if ($urandom_range(0, 29) == 0)
                settle_block();
        end

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/ccp_pkg.sv
src/ccp_ram.sv
src/closest_cross_team_pair.sv
tb/ccp_pair_checker.sv
tb/tb_top.sv
